@@ sv/prfr_pkg.sv @@
package prfr_pkg;

    localparam logic [7:0] HDR1     = 8'hAA;
    localparam logic [7:0] HDR2     = 8'hFF;
    localparam logic [7:0] ID_READ  = 8'hE1;
    localparam logic [7:0] ID_WRITE = 8'hE2;
    localparam logic [7:0] ID_CHECK = 8'h00;

    localparam logic [7:0] PARAM_BODY_LEN = 8'd6;
    localparam logic [7:0] CHECK_BODY_LEN = 8'd3;
    localparam logic [4:0] PARAM_LEN      = 5'd12;
    localparam logic [4:0] CHECK_LEN      = 5'd9;

    localparam logic [15:0] PID_SPEED = 16'd1;
    localparam logic [15:0] PID_NONE  = 16'd2;

    localparam int CAP_DEPTH        = 6;
    localparam int QUEUE_DEPTH_DFLT = 2;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_IDENT   = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SUM     = 3'd5,
        PH_ADD     = 3'd6
    } phase_t;

    typedef struct packed {
        logic               send_param;
        logic [15:0]        pid;
        logic [31:0]        value;
        logic [7:0]         ident;
        logic [7:0]         rx_sum;
        logic [7:0]         rx_add;
        logic signed [31:0] speed;
        logic               written;
    } job_t;

endpackage

@@ sv/prfr_front.sv @@
module prfr_front
    import prfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               req_type,
    input  logic [7:0]         rx_byte,
    input  logic signed [31:0] speed_in,
    output logic               push,
    output job_t               job
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  ident_reg, ident_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  add_reg, add_next;
    logic [7:0]  rxsum_reg, rxsum_next;
    logic [7:0]  cap_reg [CAP_DEPTH];
    logic [7:0]  cap_next [CAP_DEPTH];
    logic [31:0] speed_reg, speed_next;

    logic [7:0]  sum_acc, add_acc;
    logic [15:0] pid;
    logic [31:0] wr_value;
    logic [7:0]  cnt_inc;
    logic        good, is_write;

    assign sum_acc  = sum_reg + rx_byte;
    assign add_acc  = add_reg + sum_acc;
    assign cnt_inc  = cnt_reg + 8'd1;
    assign pid      = {cap_reg[1], cap_reg[0]};
    assign wr_value = {cap_reg[5], cap_reg[4], cap_reg[3], cap_reg[2]};
    assign good     = (sum_reg == rxsum_reg) && (add_reg == rx_byte);
    assign is_write = (ident_reg == ID_WRITE) && (pid == PID_SPEED);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        ident_next = ident_reg;
        sum_next   = sum_reg;
        add_next   = add_reg;
        rxsum_next = rxsum_reg;
        speed_next = speed_reg;
        cap_next   = cap_reg;
        push       = 1'b0;
        if (accept && req_type)
        begin
            speed_next = speed_in;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == HDR1)
                    begin
                        sum_next   = rx_byte;
                        add_next   = rx_byte;
                        len_next   = 8'd0;
                        cnt_next   = 8'd0;
                        for (int i = 0; i < CAP_DEPTH; i++)
                        begin
                            cap_next[i] = 8'd0;
                        end
                        phase_next = PH_HDR2;
                    end
                end
                PH_HDR2:
                begin
                    if (rx_byte == HDR2)
                    begin
                        sum_next   = sum_acc;
                        add_next   = add_acc;
                        phase_next = PH_IDENT;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_IDENT:
                begin
                    ident_next = rx_byte;
                    sum_next   = sum_acc;
                    add_next   = add_acc;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = rx_byte;
                    cnt_next   = 8'd0;
                    sum_next   = sum_acc;
                    add_next   = add_acc;
                    phase_next = (rx_byte == 8'd0) ? PH_SUM : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (cnt_reg < 8'(CAP_DEPTH))
                    begin
                        cap_next[cnt_reg[2:0]] = rx_byte;
                    end
                    sum_next = sum_acc;
                    add_next = add_acc;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= len_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    rxsum_next = rx_byte;
                    phase_next = PH_ADD;
                end
                PH_ADD:
                begin
                    phase_next = PH_HUNT;
                    if (good)
                    begin
                        push = 1'b1;
                        if (is_write)
                        begin
                            speed_next = wr_value;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        job.send_param = (ident_reg == ID_READ) && (pid != PID_NONE);
        job.pid        = pid;
        job.value      = (pid == PID_SPEED) ? speed_reg : 32'd0;
        job.ident      = ident_reg;
        job.rx_sum     = rxsum_reg;
        job.rx_add     = rx_byte;
        job.speed      = is_write ? wr_value : speed_reg;
        job.written    = is_write;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            ident_reg <= 8'd0;
            sum_reg   <= 8'd0;
            add_reg   <= 8'd0;
            rxsum_reg <= 8'd0;
            speed_reg <= 32'd0;
            for (int i = 0; i < CAP_DEPTH; i++)
            begin
                cap_reg[i] <= 8'd0;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            ident_reg <= ident_next;
            sum_reg   <= sum_next;
            add_reg   <= add_next;
            rxsum_reg <= rxsum_next;
            speed_reg <= speed_next;
            cap_reg   <= cap_next;
        end
    end

endmodule

@@ sv/prfr_queue.sv @@
module prfr_queue
    import prfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DFLT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ sv/prfr_back.sv @@
module prfr_back
    import prfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  job_t               head_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         tx_byte,
    output logic               frame_end,
    output logic               run_last,
    output logic signed [31:0] speed_out,
    output logic               speed_written
);

    logic [4:0]  idx_reg;
    logic [7:0]  sc_reg, ac_reg;
    logic        out_valid_reg;
    logic [7:0]  tx_byte_reg;
    logic        frame_end_reg, run_last_reg, written_reg;
    logic [31:0] speed_reg;

    logic        load, is_param, body_pos, frame_last;
    logic [4:0]  local_idx, frame_len;
    logic [3:0]  fb;
    logic [7:0]  cur_byte, sc_base, ac_base, sc_new, ac_new;

    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign is_param  = head_job.send_param && (idx_reg < PARAM_LEN);
    assign local_idx = (head_job.send_param && !is_param) ? idx_reg - PARAM_LEN : idx_reg;
    assign fb        = local_idx[3:0];
    assign frame_len = is_param ? PARAM_LEN : CHECK_LEN;
    assign frame_last = (local_idx == frame_len - 5'd1);
    assign body_pos  = (local_idx < frame_len - 5'd2);

    always_comb
    begin
        cur_byte = 8'd0;
        if (is_param)
        begin
            unique case (fb)
                4'd0:    cur_byte = HDR1;
                4'd1:    cur_byte = HDR2;
                4'd2:    cur_byte = ID_READ;
                4'd3:    cur_byte = PARAM_BODY_LEN;
                4'd4:    cur_byte = head_job.pid[7:0];
                4'd5:    cur_byte = head_job.pid[15:8];
                4'd6:    cur_byte = head_job.value[7:0];
                4'd7:    cur_byte = head_job.value[15:8];
                4'd8:    cur_byte = head_job.value[23:16];
                4'd9:    cur_byte = head_job.value[31:24];
                4'd10:   cur_byte = sc_reg;
                default: cur_byte = ac_reg;
            endcase
        end
        else
        begin
            unique case (fb)
                4'd0:    cur_byte = HDR1;
                4'd1:    cur_byte = HDR2;
                4'd2:    cur_byte = ID_CHECK;
                4'd3:    cur_byte = CHECK_BODY_LEN;
                4'd4:    cur_byte = head_job.ident;
                4'd5:    cur_byte = head_job.rx_sum;
                4'd6:    cur_byte = head_job.rx_add;
                4'd7:    cur_byte = sc_reg;
                default: cur_byte = ac_reg;
            endcase
        end
    end

    assign sc_base = (fb == 4'd0) ? 8'd0 : sc_reg;
    assign ac_base = (fb == 4'd0) ? 8'd0 : ac_reg;
    assign sc_new  = sc_base + cur_byte;
    assign ac_new  = ac_base + sc_new;
    assign pop     = load && frame_last && !is_param;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 5'd0;
            sc_reg        <= 8'd0;
            ac_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= pop ? 5'd0 : idx_reg + 5'd1;
                out_valid_reg <= 1'b1;
                if (body_pos)
                begin
                    sc_reg <= sc_new;
                    ac_reg <= ac_new;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tx_byte_reg   <= cur_byte;
            frame_end_reg <= frame_last;
            run_last_reg  <= frame_last && !is_param;
            speed_reg     <= head_job.speed;
            written_reg   <= head_job.written;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_byte       = tx_byte_reg;
    assign frame_end     = frame_end_reg;
    assign run_last      = run_last_reg;
    assign speed_out     = speed_reg;
    assign speed_written = written_reg;

endmodule

@@ sv/param_frame_receiver_responder.sv @@
// Serial parameter frame receiver and responder. Requests are taken one per cycle:
// a received byte or an external speed update. The parser checks 0xAA 0xFF framing
// and both 8-bit checksums; each frame that passes queues one reply job, which the
// reply generator turns into a 9-byte check frame, preceded by a 12-byte parameter
// frame for a read of ident 0xE1 unless the parameter id is 2. Reply bytes leave one
// per cycle through an output register while out_stall is low. The job being sent
// stays in the reply queue until its last byte, and the input is stalled while the
// queue is full (QUEUE_DEPTH jobs, the one being sent included). With the default
// depth and a free-running output this happens when a job arrives before the one
// ahead of it has sent all of its bytes. No clearing pass.
module param_frame_receiver_responder
    import prfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [7:0]         rx_byte,
    input  logic signed [31:0] speed_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         tx_byte,
    output logic               frame_end,
    output logic               run_last,
    output logic signed [31:0] speed_out,
    output logic               speed_written
);

    logic accept, push, pop, full, head_valid;
    job_t push_job, head_job;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    prfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .rx_byte  (rx_byte),
        .speed_in (speed_in),
        .push     (push),
        .job      (push_job)
    );

    prfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    prfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_byte       (tx_byte),
        .frame_end     (frame_end),
        .run_last      (run_last),
        .speed_out     (speed_out),
        .speed_written (speed_written)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("reply job pushed into a full queue");

    a_update_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type) |-> !push)
        else $error("speed update produced a reply job");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_last) |-> frame_end)
        else $error("last reply byte not at a frame end");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("reply queue popped while empty");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import prfr_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic [7:0]         tx;
        bit                 fend;
        bit                 rlast;
        logic signed [31:0] spd;
        bit                 wr;
    } reply_t;

    typedef struct {
        bit                 rt;
        logic [7:0]         b;
        logic signed [31:0] sp;
        bit                 quiet;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               req_type = 1'b0;
    logic [7:0]         rx_byte = 8'h00;
    logic signed [31:0] speed_in = 32'sd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         tx_byte;
    logic               frame_end;
    logic               run_last;
    logic signed [31:0] speed_out;
    logic               speed_written;

    // parser copy
    phase_t             ph = PH_HUNT;
    logic [7:0]         flen = 8'h00;
    logic [7:0]         fcnt = 8'h00;
    logic [7:0]         fid = 8'h00;
    logic [7:0]         csum = 8'h00;
    logic [7:0]         cadd = 8'h00;
    logic [7:0]         got_sum = 8'h00;
    logic [7:0]         cap [CAP_DEPTH] = '{default: 8'h00};
    logic signed [31:0] speed = 32'sd0;

    logic [7:0]         step_bytes[$];
    bit                 step_ends[$];
    reply_t             reply_q[$];
    stim_row_t          stim_tab[$];

    bit                 calm = 1'b0;
    int                 errors = 0;
    int                 req_count = 0;
    int                 replies_seen = 0;
    int                 good_frames = 0;
    int                 speed_loads = 0;
    int                 bad_sums = 0;
    int                 cut_frames = 0;

    param_frame_receiver_responder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .rx_byte       (rx_byte),
        .speed_in      (speed_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_byte       (tx_byte),
        .frame_end     (frame_end),
        .run_last      (run_last),
        .speed_out     (speed_out),
        .speed_written (speed_written)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 33);
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] wanted);
        errors++;
        if (errors <= 40)
            $display("mismatch %s: got %h wanted %h at %0t ns", what, got, wanted, $time);
    endtask

    task fold_byte(input logic [7:0] b);
        csum = csum + b;
        cadd = cadd + csum;
    endtask

    task append_frame(input logic [7:0] ident, input logic [7:0] len, input logic [47:0] body);
        logic [7:0] sc;
        logic [7:0] ac;
        logic [7:0] cur;
        int         i;
        sc = 8'h00;
        ac = 8'h00;
        for (i = 0; i < 4 + len; i++)
        begin
            if (i == 0)
                cur = HDR1;
            else if (i == 1)
                cur = HDR2;
            else if (i == 2)
                cur = ident;
            else if (i == 3)
                cur = len;
            else
                cur = body[8 * (i - 4) +: 8];
            step_bytes.push_back(cur);
            step_ends.push_back(1'b0);
            sc = sc + cur;
            ac = ac + sc;
        end
        step_bytes.push_back(sc);
        step_ends.push_back(1'b0);
        step_bytes.push_back(ac);
        step_ends.push_back(1'b1);
    endtask

    task predict_reply(input bit rt, input logic [7:0] b, input logic signed [31:0] sp,
                       input bit quiet);
        logic [15:0] pid;
        logic [31:0] v;
        bit          wr;
        reply_t      r;
        step_bytes.delete();
        step_ends.delete();
        wr = 1'b0;
        if (rt)
        begin
            speed = sp;
            speed_loads++;
            return;
        end
        case (ph)
            PH_HUNT:
            begin
                if (b == HDR1)
                begin
                    csum = 8'h00;
                    cadd = 8'h00;
                    fold_byte(b);
                    flen = 8'h00;
                    fcnt = 8'h00;
                    foreach (cap[i])
                        cap[i] = 8'h00;
                    ph = PH_HDR2;
                end
            end
            PH_HDR2:
            begin
                if (b == HDR2)
                begin
                    fold_byte(b);
                    ph = PH_IDENT;
                end
                else
                    ph = PH_HUNT;
            end
            PH_IDENT:
            begin
                fid = b;
                fold_byte(b);
                ph = PH_LEN;
            end
            PH_LEN:
            begin
                flen = b;
                fcnt = 8'h00;
                fold_byte(b);
                ph = (b == 8'h00) ? PH_SUM : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (fcnt < CAP_DEPTH)
                    cap[fcnt] = b;
                fold_byte(b);
                fcnt = fcnt + 8'd1;
                if (fcnt >= flen)
                    ph = PH_SUM;
            end
            PH_SUM:
            begin
                got_sum = b;
                ph = PH_ADD;
            end
            PH_ADD:
            begin
                ph = PH_HUNT;
                if (csum == got_sum && cadd == b)
                begin
                    good_frames++;
                    pid = {cap[1], cap[0]};
                    if (fid == ID_READ && pid != PID_NONE)
                    begin
                        v = (pid == PID_SPEED) ? speed : 32'h0;
                        append_frame(ID_READ, PARAM_BODY_LEN, {v, pid});
                    end
                    if (fid == ID_WRITE && pid == PID_SPEED)
                    begin
                        speed = {cap[5], cap[4], cap[3], cap[2]};
                        wr = 1'b1;
                    end
                    append_frame(ID_CHECK, CHECK_BODY_LEN, {24'h0, b, got_sum, fid});
                end
            end
            default:
                ph = PH_HUNT;
        endcase
        if (quiet)
            return;
        foreach (step_bytes[i])
        begin
            r.tx = step_bytes[i];
            r.fend = step_ends[i];
            r.rlast = (i == step_bytes.size() - 1);
            r.spd = speed;
            r.wr = wr;
            reply_q.push_back(r);
        end
    endtask

    function automatic byte_q_t build_frame(input logic [7:0] ident, input logic [7:0] len,
                                            input logic [47:0] lead, input bit corrupt);
        byte_q_t    q;
        logic [7:0] sc;
        logic [7:0] ac;
        int         i;
        q.push_back(HDR1);
        q.push_back(HDR2);
        q.push_back(ident);
        q.push_back(len);
        for (i = 0; i < len; i++)
            q.push_back((i < 6) ? lead[8 * i +: 8] : 8'($urandom));
        sc = 8'h00;
        ac = 8'h00;
        foreach (q[j])
        begin
            sc = sc + q[j];
            ac = ac + sc;
        end
        if (corrupt)
        begin
            if ($urandom_range(0, 1) == 1)
                sc = sc ^ 8'(1 << $urandom_range(0, 7));
            else
                ac = ac ^ 8'(1 << $urandom_range(0, 7));
        end
        q.push_back(sc);
        q.push_back(ac);
        return q;
    endfunction

    task automatic push_req(input bit rt, input logic [7:0] b, input logic signed [31:0] sp,
                            input bit quiet);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        rx_byte <= b;
        speed_in <= sp;
        do
            @(posedge clk);
        while (in_stall);
        req_count++;
        predict_reply(rt, b, sp, quiet);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= take_break();
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            replies_seen++;
            if (reply_q.size() == 0)
                report_mismatch("reply with nothing pending", tx_byte, 32'h0);
            else
            begin
                want = reply_q.pop_front();
                if (tx_byte !== want.tx)
                    report_mismatch("tx_byte", tx_byte, want.tx);
                if (frame_end !== want.fend)
                    report_mismatch("frame_end", frame_end, want.fend);
                if (run_last !== want.rlast)
                    report_mismatch("run_last", run_last, want.rlast);
                if (speed_out !== want.spd)
                    report_mismatch("speed_out", speed_out, want.spd);
                if (speed_written !== want.wr)
                    report_mismatch("speed_written", speed_written, want.wr);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timed out with %0d replies pending", reply_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        byte_q_t     fb;
        int          base;
        int          kind;
        int          n;
        bit          paused;
        logic [7:0]  ident;
        logic [7:0]  len;
        logic [15:0] pid;
        bit          corrupt;
        logic [31:0] val;

        // reset state, bad second header, speed load at its minimum
        stim_tab.push_back('{1'b0, 8'h00, 32'sd0, 1'b1});
        stim_tab.push_back('{1'b0, 8'hFF, 32'sd0, 1'b1});
        stim_tab.push_back('{1'b0, 8'hAA, 32'sd0, 1'b1});
        stim_tab.push_back('{1'b0, 8'hAA, 32'sd0, 1'b1});
        stim_tab.push_back('{1'b1, 8'h00, 32'sh80000000, 1'b1});
        // read of the speed register, then write of its maximum
        fb = build_frame(ID_READ, 8'd2, {32'h0, PID_SPEED}, 1'b0);
        foreach (fb[i])
            stim_tab.push_back('{1'b0, fb[i], 32'sd0, i != fb.size() - 1});
        fb = build_frame(ID_WRITE, 8'd6, {32'h7FFFFFFF, PID_SPEED}, 1'b0);
        foreach (fb[i])
            stim_tab.push_back('{1'b0, fb[i], 32'sd0, i != fb.size() - 1});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_tab[i])
            push_req(stim_tab[i].rt, stim_tab[i].b, stim_tab[i].sp, stim_tab[i].quiet);

        in_valid <= 1'b0;
        @(posedge clk);
        while (reply_q.size() != 0)
            @(posedge clk);

        base = req_count;
        paused = 1'b0;
        while (req_count < base + 430)
        begin
            calm = (req_count >= base + 150) && (req_count < base + 260);
            if (!paused && req_count >= base + 300)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (reply_q.size() != 0)
                    @(posedge clk);
            end
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                n = $urandom_range(0, 99);
                ident = (n < 35) ? ID_READ : (n < 70) ? ID_WRITE :
                        (n < 80) ? ID_CHECK : 8'($urandom);
                n = $urandom_range(0, 99);
                pid = (n < 45) ? PID_SPEED : (n < 65) ? PID_NONE : 16'($urandom);
                n = $urandom_range(0, 99);
                len = (n < 80) ? 8'($urandom_range(0, 8)) :
                      (n < 95) ? 8'($urandom_range(9, 24)) : 8'($urandom_range(25, 60));
                corrupt = ($urandom_range(0, 99) < 12);
                if (corrupt)
                    bad_sums++;
                fb = build_frame(ident, len, {32'($urandom), pid}, corrupt);
                n = fb.size();
                if (kind >= 70)
                begin
                    // cut-off frame
                    n = $urandom_range(1, fb.size() - 1);
                    cut_frames++;
                end
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 99) < 4)
                        push_req(1'b1, 8'($urandom), 32'($urandom), 1'b0);
                    push_req(1'b0, fb[i], 32'($urandom), 1'b0);
                end
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(1, 4))
                    push_req(1'b0, ($urandom_range(0, 99) < 30) ? HDR1 : 8'($urandom),
                             32'($urandom), 1'b0);
            end
            else
            begin
                n = $urandom_range(0, 99);
                val = (n < 20) ? 32'h80000000 : (n < 40) ? 32'h7FFFFFFF : $urandom;
                push_req(1'b1, 8'($urandom), val, 1'b0);
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("requests %0d, of them %0d directed and %0d speed loads",
                 req_count, stim_tab.size(), speed_loads);
        $display("frames passing checksum %0d, corrupted %0d, cut off %0d, reply bytes %0d",
                 good_frames, bad_sums, cut_frames, replies_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
